### src/srm_pkg.sv
// Shared types, constants and the sine table for the stereo ring modulator.
package srm_pkg;

    localparam int SAMPLE_W        = 24;
    localparam int SINE_W          = 16;
    localparam int PHASE_W         = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_SIZE       = 1 << SINE_TABLE_BITS;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int PROD_W          = SAMPLE_W + SINE_W;
    localparam int ROUND_SHIFT     = SINE_W - 1;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] COEF_A1 = 64'd1686629713;
    localparam logic [63:0] COEF_A3 = 64'd693598668;
    localparam logic [63:0] COEF_A5 = 64'd85569318;
    localparam logic [63:0] COEF_A7 = 64'd5026998;
    localparam logic [63:0] COEF_A9 = 64'd172272;
    localparam logic [63:0] SINE_MAX = 64'd32767;

    typedef logic signed [SINE_W-1:0] sine_tab_t [SINE_SIZE];

    typedef struct packed {
        logic signed [SINE_W-1:0]   sine;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } frame_t;

    function automatic sine_tab_t build_sine_table();
        sine_tab_t   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] mag;
        logic [1:0]  q;
        logic [63:0] r;
        for (int k = 0; k < SINE_SIZE; k++) begin
            q = 2'(k >> (SINE_TABLE_BITS - 2));
            r = 64'(k & ((1 << (SINE_TABLE_BITS - 2)) - 1));
            x = r << (32 - SINE_TABLE_BITS);
            if (q[0])
                x = Q30_ONE - x;
            x2  = (x * x) >> 30;
            p   = COEF_A9;
            p   = COEF_A7 - ((p * x2) >> 30);
            p   = COEF_A5 - ((p * x2) >> 30);
            p   = COEF_A3 - ((p * x2) >> 30);
            p   = COEF_A1 - ((p * x2) >> 30);
            s   = (x * p) >> 30;
            mag = (s + (64'd1 << 14)) >> 15;
            if (mag > SINE_MAX)
                mag = SINE_MAX;
            tab[k] = q[1] ? -SINE_W'(mag) : SINE_W'(mag);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

### src/srm_front.sv
// Front end: accepts frames, runs the phase accumulator and looks up the sine.
module srm_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               phase_step_wr,
    input  logic [srm_pkg::PHASE_W-1:0]        phase_step_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [srm_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [srm_pkg::SAMPLE_W-1:0] right_in,
    output logic                               push,
    output srm_pkg::frame_t                    push_item,
    input  logic                               queue_full
);
    import srm_pkg::*;

    logic [PHASE_W-1:0] step_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic               valid_reg;
    logic               valid_next;
    frame_t             item_reg;
    logic               accept;

    assign push     = valid_reg && !queue_full;
    assign in_ready = !valid_reg || !queue_full;
    assign accept   = in_valid && in_ready;
    assign push_item = item_reg;

    always_comb
    begin
        phase_next = accept ? phase_reg + step_reg : phase_reg;
        if (accept)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            phase_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (phase_step_wr)
                step_reg <= phase_step_data;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.sine  <= SINE_TABLE[phase_reg[PHASE_W-1 -: SINE_TABLE_BITS]];
            item_reg.left  <= left_in;
            item_reg.right <= right_in;
        end
    end

endmodule

### src/srm_queue.sv
// Short queue of looked-up frames between the front and back ends.
module srm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  srm_pkg::frame_t push_item,
    output logic            full,
    input  logic            pop,
    output srm_pkg::frame_t head,
    output logic            empty
);
    import srm_pkg::*;

    frame_t              mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;

    assign full  = count_reg == QUEUE_CW'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");

endmodule

### src/srm_back.sv
// Back end: multiplies both samples by the sine, rounds, saturates, registers.
module srm_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  srm_pkg::frame_t                     head,
    input  logic                                empty,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [srm_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [srm_pkg::SAMPLE_W-1:0] right_out
);
    import srm_pkg::*;

    localparam int SHIFT_W = PROD_W + 1 - ROUND_SHIFT;

    logic                       valid_reg;
    logic signed [SAMPLE_W-1:0] left_reg;
    logic signed [SAMPLE_W-1:0] right_reg;
    logic signed [SAMPLE_W-1:0] left_next;
    logic signed [SAMPLE_W-1:0] right_next;

    function automatic logic signed [SAMPLE_W-1:0] modulate(
        input logic signed [SAMPLE_W-1:0] sample,
        input logic signed [SINE_W-1:0]   sine
    );
        logic signed [PROD_W-1:0]  prod;
        logic signed [PROD_W:0]    biased;
        logic signed [SHIFT_W-1:0] v;
        logic signed [SHIFT_W-1:0] hi;
        logic signed [SHIFT_W-1:0] lo;
        prod   = PROD_W'(sample) * PROD_W'(sine);
        biased = (PROD_W+1)'(prod) + ((PROD_W+1)'(1) <<< (ROUND_SHIFT - 1));
        v      = SHIFT_W'(biased >>> ROUND_SHIFT);
        hi     = SHIFT_W'((1 << (SAMPLE_W - 1)) - 1);
        lo     = -SHIFT_W'(1 << (SAMPLE_W - 1));
        if (v > hi)
            v = hi;
        else if (v < lo)
            v = lo;
        return SAMPLE_W'(v);
    endfunction

    assign pop       = !empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign left_out  = left_reg;
    assign right_out = right_reg;

    always_comb
    begin
        left_next  = modulate(head.left, head.sine);
        right_next = modulate(head.right, head.sine);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

endmodule

### src/stereo_ring_modulator.sv
// Top level of the stereo ring modulator.
//
// Input stream s_axis: one stereo frame per transfer, tdata = {right_in, left_in}.
// Output stream m_axis: one modulated frame per input frame, same packing.
// Both samples are multiplied by the sine at the current oscillator phase,
// rounded back to Q1.23 and saturated; the phase then advances by phase_step.
// phase_step is written through phase_step_wr / phase_step_data; the user must
// do so only while idle, as the block itself does not enforce it. Throughput:
// one frame per cycle, sustained while m_axis_tready stays high. A frame
// passes the sine table read register, the queue and the output register on
// its way to m_axis.
// A four-entry queue separates the sine lookup from the multipliers, so the
// input keeps accepting while a result waits; once the queue and both stage
// registers fill under a stalled m_axis_tready, s_axis_tready drops.
// Reset clears the phase, phase_step and all valid state.
module stereo_ring_modulator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        phase_step_wr,
    input  logic [31:0] phase_step_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // left_in [23:0], right_in [47:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // left_out [23:0], right_out [47:24]
);
    import srm_pkg::*;

    logic                       push;
    logic                       pop;
    logic                       queue_full;
    logic                       queue_empty;
    frame_t                     push_item;
    frame_t                     head;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;

    srm_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .phase_step_wr   (phase_step_wr),
        .phase_step_data (phase_step_data),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .left_in         (s_axis_tdata[23:0]),
        .right_in        (s_axis_tdata[47:24]),
        .push            (push),
        .push_item       (push_item),
        .queue_full      (queue_full)
    );

    srm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty)
    );

    srm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (queue_empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .left_out  (left_out),
        .right_out (right_out)
    );

    assign m_axis_tdata = {right_out, left_out};

endmodule
